// File: sv/chunked_page_free_list_unit_assert.svh
// assertion macros for the page free list
`ifndef CHUNKED_PAGE_FREE_LIST_UNIT_ASSERT_SVH
`define CHUNKED_PAGE_FREE_LIST_UNIT_ASSERT_SVH

// expression holds at every edge out of reset
`define CPFL_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CPFL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define CPFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/cpfl_pkg.sv
package cpfl_pkg;

   // default sizing
   localparam int MAX_CHUNKS_DEF          = 16;
   localparam int MAX_PAGES_PER_CHUNK_DEF = 64;

   // field widths
   localparam int CHUNK_W     = 4;
   localparam int PAGE_W      = 6;
   localparam int ENTRY_W     = CHUNK_W + PAGE_W;
   localparam int STATUS_W    = 3;
   localparam int FREE_CNT_W  = 11;
   localparam int CHUNKS_W    = 5;
   localparam int ALLOC_CNT_W = 32;
   localparam int MAX_CFG_W   = 5;
   localparam int LOG2_CFG_W  = 3;
   localparam int CSR_DATA_W  = 5;
   localparam int CSR_INDEX_W = 1;

   // register reset values
   localparam logic [MAX_CFG_W-1:0]  MAX_CHUNK_COUNT_RST  = 5'd16;
   localparam logic [LOG2_CFG_W-1:0] CHUNK_PAGES_LOG2_RST = 3'd6;

   // request codes
   typedef enum logic {
      ACT_ALLOCATE = 1'b0,
      ACT_RELEASE  = 1'b1
   } action_type;

   // result codes
   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOC    = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RELEASED = 3'd2,
      ST_INVALID  = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_CHUNK_COUNT  = 1'b0,
      CSR_CHUNK_PAGES_LOG2 = 1'b1
   } csr_index_type;

   // controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

endpackage

// File: sv/cpfl_if.sv
interface cpfl_req_if;
   import cpfl_pkg::*;

   logic                valid;
   logic                ready;
   logic                action;
   logic [CHUNK_W-1:0]  rel_chunk;
   logic [PAGE_W-1:0]   rel_page;
   logic                rel_valid;
   logic                batch_last;

   modport source (output valid, action, rel_chunk, rel_page, rel_valid, batch_last,
                   input ready);
   modport sink   (input valid, action, rel_chunk, rel_page, rel_valid, batch_last,
                   output ready);
endinterface

interface cpfl_rsp_if;
   import cpfl_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [CHUNK_W-1:0]     page_chunk;
   logic [PAGE_W-1:0]      page_index;
   logic [FREE_CNT_W-1:0]  free_count;
   logic [CHUNKS_W-1:0]    chunks_used;
   logic [ALLOC_CNT_W-1:0] total_allocated;

   modport source (output valid, status, page_chunk, page_index, free_count, chunks_used,
                          total_allocated,
                   input ready);
   modport sink   (input valid, status, page_chunk, page_index, free_count, chunks_used,
                         total_allocated,
                   output ready);
endinterface

interface cpfl_csr_if;
   import cpfl_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/chunked_page_free_list_unit.sv
// FIFO free-list page allocator.
// req: one transfer per request; action 0 pops the oldest free page, action 1
// appends rel_chunk/rel_page when rel_valid is set. batch_last is carried but
// has no effect. rsp: exactly one transfer per request, in request order,
// with status, the allocated page and the counters after the request.
// csr: register writes, index 0 max_chunk_count, index 1 chunk_pages_log2,
// always ready; write only while no request is outstanding.
// An empty list with chunk budget left is refilled lazily: a fresh-page
// counter hands out the pages of the new chunk, so only released pages live
// in the store memory (one write port, one read port with registered data).
// Throughput: one request per cycle while rsp is not stalled; no new request
// is taken while an allocation served from the store memory waits for its read.
// The response is registered and appears in the cycle after the request
// transfer; a memory-served allocation passes the read data register first.
// Reset empties the list and clears the entry, chunk and allocation counters; the store memory is not
// cleared, as every entry is written before it is read.
// A stalled rsp holds its result; a new request is taken only while the
// response register is empty or draining in the same cycle.
`include "chunked_page_free_list_unit_assert.svh"

module chunked_page_free_list_unit #(
   parameter int MAX_CHUNKS          = cpfl_pkg::MAX_CHUNKS_DEF,
   parameter int MAX_PAGES_PER_CHUNK = cpfl_pkg::MAX_PAGES_PER_CHUNK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cpfl_req_if.sink    req,
   cpfl_rsp_if.source  rsp,
   cpfl_csr_if.sink    csr
);
   import cpfl_pkg::*;

   localparam int CAP   = MAX_CHUNKS * MAX_PAGES_PER_CHUNK;
   localparam int PTR_W = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int CNT_W = $clog2(CAP + 1);
   localparam int CHK_W = $clog2(MAX_CHUNKS + 1);
   localparam int PG_W  = $clog2(MAX_PAGES_PER_CHUNK + 1);

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAP - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAP);

   // control and counters
   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [PTR_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        entry_count_ff, entry_count_in;
   logic [CHK_W-1:0]        chunk_counter_ff, chunk_counter_in;
   logic [ALLOC_CNT_W-1:0]  alloc_counter_ff, alloc_counter_in;
   logic [PG_W-1:0]         fresh_left_ff, fresh_left_in;
   logic [PG_W-1:0]         fresh_next_ff, fresh_next_in;
   logic [CHK_W-1:0]        fresh_chunk_ff, fresh_chunk_in;
   logic [MAX_CFG_W-1:0]    max_chunk_count_ff;
   logic [LOG2_CFG_W-1:0]   chunk_pages_log2_ff;

   // response register
   status_type              status_ff, status_in;
   logic [CHUNK_W-1:0]      page_chunk_ff, page_chunk_in;
   logic [PAGE_W-1:0]       page_index_ff, page_index_in;
   logic [FREE_CNT_W-1:0]   free_count_ff, free_count_in;
   logic [CHUNKS_W-1:0]     chunks_used_ff, chunks_used_in;
   logic [ALLOC_CNT_W-1:0]  total_alloc_ff, total_alloc_in;

   // store memory
   logic [ENTRY_W-1:0]      store_mem [CAP];
   logic [ENTRY_W-1:0]      rd_data_ff;
   logic                    rd_en;
   logic                    mem_we;

   logic                    accept;
   logic                    chunk_allowed;
   logic [8:0]              pow_pages;
   logic [PG_W-1:0]         chunk_pages;
   logic                    load;
   status_type              ld_status;
   logic [CHUNK_W-1:0]      ld_chunk;
   logic [PAGE_W-1:0]       ld_page;

   assign req.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // chunk budget, saturated at MAX_CHUNKS
   assign chunk_allowed = (32'(max_chunk_count_ff) > MAX_CHUNKS)
                        ? (32'(chunk_counter_ff) < MAX_CHUNKS)
                        : (32'(chunk_counter_ff) < 32'(max_chunk_count_ff));

   // pages per new chunk, capped at the chunk size limit
   assign pow_pages   = 9'd1 << chunk_pages_log2_ff;
   assign chunk_pages = (32'(pow_pages) > MAX_PAGES_PER_CHUNK)
                      ? PG_W'(MAX_PAGES_PER_CHUNK) : PG_W'(pow_pages);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (rd_en) state_in = S_READ;
         S_READ:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // request handling and response load
   always_comb begin
      head_in          = head_ff;
      tail_in          = tail_ff;
      entry_count_in   = entry_count_ff;
      chunk_counter_in = chunk_counter_ff;
      alloc_counter_in = alloc_counter_ff;
      fresh_left_in    = fresh_left_ff;
      fresh_next_in    = fresh_next_ff;
      fresh_chunk_in   = fresh_chunk_ff;
      rd_en            = 1'b0;
      mem_we           = 1'b0;
      load             = 1'b0;
      ld_status        = ST_ALLOC;
      ld_chunk         = '0;
      ld_page          = '0;
      rsp_valid_in     = rsp_valid_ff && !rsp.ready;
      status_in        = status_ff;
      page_chunk_in    = page_chunk_ff;
      page_index_in    = page_index_ff;
      free_count_in    = free_count_ff;
      chunks_used_in   = chunks_used_ff;
      total_alloc_in   = total_alloc_ff;

      case (state_ff)
         S_READ: begin
            // memory-served pop, counters were updated at the request
            load      = 1'b1;
            ld_status = ST_ALLOC;
            ld_chunk  = rd_data_ff[ENTRY_W-1:PAGE_W];
            ld_page   = rd_data_ff[PAGE_W-1:0];
         end
         default: begin
            if (accept) begin
               if (req.action == ACT_ALLOCATE) begin
                  if (entry_count_ff == '0) begin
                     if (!chunk_allowed) begin
                        load      = 1'b1;
                        ld_status = ST_EMPTY;
                     end else begin
                        // new chunk: hand out page 0, keep the rest as fresh pages
                        fresh_chunk_in   = chunk_counter_ff;
                        fresh_next_in    = PG_W'(1);
                        fresh_left_in    = chunk_pages - PG_W'(1);
                        entry_count_in   = CNT_W'(chunk_pages - PG_W'(1));
                        chunk_counter_in = chunk_counter_ff + CHK_W'(1);
                        alloc_counter_in = alloc_counter_ff + ALLOC_CNT_W'(1);
                        load             = 1'b1;
                        ld_status        = ST_ALLOC;
                        ld_chunk         = CHUNK_W'(chunk_counter_ff);
                        ld_page          = '0;
                     end
                  end else if (fresh_left_ff != '0) begin
                     // fresh pages sit ahead of any released page
                     fresh_next_in    = fresh_next_ff + PG_W'(1);
                     fresh_left_in    = fresh_left_ff - PG_W'(1);
                     entry_count_in   = entry_count_ff - CNT_W'(1);
                     alloc_counter_in = alloc_counter_ff + ALLOC_CNT_W'(1);
                     load             = 1'b1;
                     ld_status        = ST_ALLOC;
                     ld_chunk         = CHUNK_W'(fresh_chunk_ff);
                     ld_page          = PAGE_W'(fresh_next_ff);
                  end else begin
                     // pop from the store, read data is registered for the S_READ state
                     rd_en            = 1'b1;
                     head_in          = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_W'(1);
                     entry_count_in   = entry_count_ff - CNT_W'(1);
                     alloc_counter_in = alloc_counter_ff + ALLOC_CNT_W'(1);
                  end
               end else if (!req.rel_valid) begin
                  load      = 1'b1;
                  ld_status = ST_INVALID;
               end else if (entry_count_ff == FULL_CNT) begin
                  load      = 1'b1;
                  ld_status = ST_OVERFLOW;
               end else begin
                  mem_we         = 1'b1;
                  tail_in        = (tail_ff == LAST_SLOT) ? '0 : tail_ff + PTR_W'(1);
                  entry_count_in = entry_count_ff + CNT_W'(1);
                  load           = 1'b1;
                  ld_status      = ST_RELEASED;
               end
            end
         end
      endcase

      // counters in the response are those after the request
      if (load) begin
         rsp_valid_in   = 1'b1;
         status_in      = ld_status;
         page_chunk_in  = ld_chunk;
         page_index_in  = ld_page;
         free_count_in  = FREE_CNT_W'(entry_count_in);
         chunks_used_in = CHUNKS_W'(chunk_counter_in);
         total_alloc_in = alloc_counter_in;
      end
   end

   // store memory; a read and a write never address a live entry together,
   // since a read needs the entry written by an earlier release
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[tail_ff] <= {req.rel_chunk, req.rel_page};
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[head_ff];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= S_IDLE;
         rsp_valid_ff        <= 1'b0;
         head_ff             <= '0;
         tail_ff             <= '0;
         entry_count_ff      <= '0;
         chunk_counter_ff    <= '0;
         alloc_counter_ff    <= '0;
         fresh_left_ff       <= '0;
         max_chunk_count_ff  <= MAX_CHUNK_COUNT_RST;
         chunk_pages_log2_ff <= CHUNK_PAGES_LOG2_RST;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         entry_count_ff   <= entry_count_in;
         chunk_counter_ff <= chunk_counter_in;
         alloc_counter_ff <= alloc_counter_in;
         fresh_left_ff    <= fresh_left_in;
         if (csr.valid && csr.ready) begin
            case (csr_index_type'(csr.index))
               CSR_MAX_CHUNK_COUNT:  max_chunk_count_ff  <= csr.data[MAX_CFG_W-1:0];
               CSR_CHUNK_PAGES_LOG2: chunk_pages_log2_ff <= csr.data[LOG2_CFG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fresh_next_ff  <= fresh_next_in;
      fresh_chunk_ff <= fresh_chunk_in;
      status_ff      <= status_in;
      page_chunk_ff  <= page_chunk_in;
      page_index_ff  <= page_index_in;
      free_count_ff  <= free_count_in;
      chunks_used_ff <= chunks_used_in;
      total_alloc_ff <= total_alloc_in;
   end

   // response outputs
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = status_ff;
   assign rsp.page_chunk      = page_chunk_ff;
   assign rsp.page_index      = page_index_ff;
   assign rsp.free_count      = free_count_ff;
   assign rsp.chunks_used     = chunks_used_ff;
   assign rsp.total_allocated = total_alloc_ff;

   // checks
   `CPFL_ASSERT_ALWAYS(a_fresh_in_list, clock, reset,
      32'(fresh_left_ff) <= 32'(entry_count_ff), "fresh pages exceed list size")
   `CPFL_ASSERT_NEXT(a_read_then_wait, clock, reset, rd_en,
      state_ff == S_READ && !rsp_valid_ff, "store read not followed by read state")
   `CPFL_ASSERT_IMPLY(a_overflow_full, clock, reset,
      rsp_valid_ff && status_ff == ST_OVERFLOW,
      entry_count_ff == FULL_CNT, "overflow reported on a list that is not full")

endmodule

// File: tb/tb_chunked_page_free_list_unit.sv
module tb_chunked_page_free_list_unit;
   import cpfl_pkg::*;

   localparam int STORE_DEPTH  = MAX_CHUNKS_DEF * MAX_PAGES_PER_CHUNK_DEF;
   localparam int EXPECT_DEPTH = 16;
   localparam int REPORT_LIMIT = 10;

   typedef logic [ENTRY_W-1:0] page_entry_type;

   typedef struct packed {
      status_type             status;
      logic [CHUNK_W-1:0]     page_chunk;
      logic [PAGE_W-1:0]      page_index;
      logic [FREE_CNT_W-1:0]  free_count;
      logic [CHUNKS_W-1:0]    chunks_used;
      logic [ALLOC_CNT_W-1:0] total_allocated;
   } page_result_type;

   logic clock;
   logic reset;

   cpfl_req_if req_bus ();
   cpfl_rsp_if rsp_bus ();
   cpfl_csr_if csr_bus ();

   chunked_page_free_list_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // allocator mirror: free list ring, chunk and allocation counters, registers
   page_entry_type         free_ring[STORE_DEPTH];
   int                     free_head       = 0;
   int                     free_tail       = 0;
   int                     free_size       = 0;
   int                     chunks_added    = 0;
   logic [ALLOC_CNT_W-1:0] pages_allocated = '0;
   logic [MAX_CFG_W-1:0]   cfg_chunk_limit = MAX_CHUNK_COUNT_RST;
   logic [LOG2_CFG_W-1:0]  cfg_pages_log2  = CHUNK_PAGES_LOG2_RST;

   // expected results in request order
   page_result_type        expect_ring[EXPECT_DEPTH];
   int                     expect_head = 0;
   int                     expect_tail = 0;
   int                     expect_size = 0;

   int mismatch_count = 0;
   bit gaps_on        = 1'b1;
   bit stalls_on      = 1'b1;
   int burst_left     = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // free list ring access
   function automatic void append_free_page(input page_entry_type entry);
      free_ring[free_tail] = entry;
      free_tail = (free_tail + 1) % STORE_DEPTH;
      free_size++;
   endfunction

   function automatic page_entry_type take_free_page();
      page_entry_type entry;
      entry = free_ring[free_head];
      free_head = (free_head + 1) % STORE_DEPTH;
      free_size--;
      return entry;
   endfunction

   // expected result ring access
   function automatic void add_expected(input page_result_type res);
      expect_ring[expect_tail] = res;
      expect_tail = (expect_tail + 1) % EXPECT_DEPTH;
      expect_size++;
   endfunction

   function automatic page_result_type take_expected();
      page_result_type res;
      res = expect_ring[expect_head];
      expect_head = (expect_head + 1) % EXPECT_DEPTH;
      expect_size--;
      return res;
   endfunction

   // work out the result of one accepted request and queue it
   function automatic void predict_page_result(input action_type act,
                                               input logic [CHUNK_W-1:0] rel_chunk,
                                               input logic [PAGE_W-1:0] rel_page,
                                               input logic rel_valid);
      page_result_type res;
      page_entry_type  entry;
      int              limit;
      int              pages;
      res = '0;
      if (act == ACT_ALLOCATE) begin
         // empty list: bring in a fresh chunk if the budget allows
         if (free_size == 0) begin
            limit = (int'(cfg_chunk_limit) > MAX_CHUNKS_DEF) ? MAX_CHUNKS_DEF
                                                             : int'(cfg_chunk_limit);
            if (chunks_added < limit) begin
               pages = 1 << cfg_pages_log2;
               if (pages > MAX_PAGES_PER_CHUNK_DEF)
                  pages = MAX_PAGES_PER_CHUNK_DEF;
               for (int i = 0; i < pages; i++)
                  append_free_page({chunks_added[CHUNK_W-1:0], i[PAGE_W-1:0]});
               chunks_added++;
            end
         end
         if (free_size == 0) begin
            res.status = ST_EMPTY;
         end else begin
            entry = take_free_page();
            res.status     = ST_ALLOC;
            res.page_chunk = entry[ENTRY_W-1:PAGE_W];
            res.page_index = entry[PAGE_W-1:0];
            pages_allocated++;
         end
      end else if (!rel_valid) begin
         res.status = ST_INVALID;
      end else if (free_size >= STORE_DEPTH) begin
         res.status = ST_OVERFLOW;
      end else begin
         append_free_page({rel_chunk, rel_page});
         res.status = ST_RELEASED;
      end
      res.free_count      = FREE_CNT_W'(free_size);
      res.chunks_used     = chunks_added[CHUNKS_W-1:0];
      res.total_allocated = pages_allocated;
      add_expected(res);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : check_results
      page_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expect_size == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("result with nothing expected: status %0d", rsp_bus.status);
         end else begin
            want = take_expected();
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
            check_field("page_chunk", 32'(want.page_chunk), 32'(rsp_bus.page_chunk));
            check_field("page_index", 32'(want.page_index), 32'(rsp_bus.page_index));
            check_field("free_count", 32'(want.free_count), 32'(rsp_bus.free_count));
            check_field("chunks_used", 32'(want.chunks_used), 32'(rsp_bus.chunks_used));
            check_field("total_allocated", want.total_allocated, rsp_bus.total_allocated);
         end
      end
   end

   // result side: ready follows a rotating random pattern, or stays high while stalls are off
   initial begin : drive_rsp_ready
      logic [15:0] ready_pattern;
      int          pattern_age;
      rsp_bus.ready = 1'b0;
      ready_pattern = 16'hffff;
      pattern_age   = 0;
      forever begin
         @(negedge clock);
         if (!stalls_on) begin
            rsp_bus.ready = 1'b1;
         end else begin
            if (pattern_age == 0)
               ready_pattern = 16'($urandom_range(0, 16'hffff)) | 16'h0001;
            rsp_bus.ready = ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            pattern_age   = (pattern_age + 1) % 48;
         end
      end
   end

   // one request transfer, with random gaps between bursts while gaps are on
   task automatic send_request(input action_type act, input logic [CHUNK_W-1:0] rel_chunk,
                               input logic [PAGE_W-1:0] rel_page, input logic rel_valid,
                               input logic batch_last);
      if (burst_left == 0) begin
         if (gaps_on)
            repeat ($urandom_range(0, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_bus.action     = act;
      req_bus.rel_chunk  = rel_chunk;
      req_bus.rel_page   = rel_page;
      req_bus.rel_valid  = rel_valid;
      req_bus.batch_last = batch_last;
      req_bus.valid      = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      predict_page_result(act, rel_chunk, rel_page, rel_valid);
      burst_left--;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expect_size != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // register write, only with nothing in flight
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_bus.index = idx;
      csr_bus.data  = value;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_MAX_CHUNK_COUNT)
         cfg_chunk_limit = value[MAX_CFG_W-1:0];
      else
         cfg_pages_log2 = value[LOG2_CFG_W-1:0];
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // zero chunk budget: allocation on the empty list runs out
   task automatic test_chunk_limit_zero();
      write_register(CSR_MAX_CHUNK_COUNT, 5'd0);
      send_request(ACT_ALLOCATE, '0, '0, 1'b0, 1'b0);
      send_request(ACT_ALLOCATE, '1, '1, 1'b1, 1'b1);
   endtask

   // one-page chunks with a budget of one chunk
   task automatic test_single_page_chunk();
      write_register(CSR_CHUNK_PAGES_LOG2, 5'd0);
      write_register(CSR_MAX_CHUNK_COUNT, 5'd1);
      send_request(ACT_ALLOCATE, '0, '0, 1'b0, 1'b0);
      send_request(ACT_ALLOCATE, '0, '0, 1'b0, 1'b0);
      send_request(ACT_ALLOCATE, '1, '1, 1'b1, 1'b1);
   endtask

   // valid and invalid releases come back in order, then four allocations
   task automatic test_release_handling();
      send_request(ACT_RELEASE, 4'd0, 6'd0, 1'b1, 1'b0);
      send_request(ACT_RELEASE, 4'd15, 6'd63, 1'b1, 1'b1);
      send_request(ACT_RELEASE, 4'd5, 6'd21, 1'b0, 1'b1);
      send_request(ACT_RELEASE, 4'd10, 6'd42, 1'b1, 1'b0);
      send_request(ACT_RELEASE, 4'd3, 6'd7, 1'b0, 1'b0);
      repeat (4) send_request(ACT_ALLOCATE, '0, '0, 1'b0, 1'b0);
   endtask

   // budget and chunk size above their maximum saturate
   task automatic test_limit_saturation();
      write_register(CSR_MAX_CHUNK_COUNT, 5'd31);
      write_register(CSR_CHUNK_PAGES_LOG2, 5'd7);
      repeat (3) send_request(ACT_ALLOCATE, '0, '0, 1'b0, 1'b0);
   endtask

   // fill the store, overflow it, then drain it with the budget below use
   task automatic test_store_overflow();
      write_register(CSR_MAX_CHUNK_COUNT, 5'd1);
      stalls_on = 1'b0;
      while (free_size < STORE_DEPTH)
         send_request(ACT_RELEASE, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                      1'b1, 1'($urandom_range(0, 1)));
      stalls_on = 1'b1;
      repeat (3) send_request(ACT_RELEASE, 4'($urandom_range(0, 15)),
                              6'($urandom_range(0, 63)), 1'b1, 1'b0);
      send_request(ACT_RELEASE, 4'd1, 6'd1, 1'b0, 1'b1);
      gaps_on = 1'b0;
      while (free_size > 0)
         send_request(ACT_ALLOCATE, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)), 1'b0);
      send_request(ACT_ALLOCATE, '0, '0, 1'b0, 1'b0);
      gaps_on = 1'b1;
   endtask

   // random allocation runs and release batches over several settings
   task automatic test_random_traffic();
      int limits[5] = '{4, 16, 16, 8, 31};
      int logs[5]   = '{2, 6, 0, 3, 1};
      int sent;
      int run;
      bit paused;
      paused = 1'b0;
      for (int phase = 0; phase < 5; phase++) begin
         write_register(CSR_MAX_CHUNK_COUNT, 5'(limits[phase]));
         write_register(CSR_CHUNK_PAGES_LOG2, 5'(logs[phase]));
         gaps_on   = phase[0];
         stalls_on = phase[1];
         sent = 0;
         while (sent < 80) begin
            if ($urandom_range(0, 99) < 55) begin
               run = $urandom_range(1, 8);
               repeat (run) begin
                  send_request(ACT_ALLOCATE, 4'($urandom_range(0, 15)),
                               6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                  sent++;
               end
            end else begin
               // release batch, last transfer marked; a few pages invalid
               run = $urandom_range(1, 6);
               for (int k = 0; k < run; k++) begin
                  send_request(ACT_RELEASE, 4'($urandom_range(0, 15)),
                               6'($urandom_range(0, 63)), $urandom_range(0, 9) != 0,
                               k == run - 1);
                  sent++;
               end
            end
            // hold off once until everything outstanding has come back
            if (phase == 2 && !paused && sent >= 40) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_ALLOCATE;
      req_bus.rel_chunk  = '0;
      req_bus.rel_page   = '0;
      req_bus.rel_valid  = 1'b0;
      req_bus.batch_last = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_MAX_CHUNK_COUNT;
      csr_bus.data       = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_chunk_limit_zero();
      test_single_page_chunk();
      test_release_handling();
      test_limit_saturation();
      test_store_overflow();
      test_random_traffic();

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expect_size == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
